// ----- hdl/tlpr_pkg.sv -----
// Package: shared types, constants and mix helpers for the token ledger.
package tlpr_pkg;

	localparam int unsigned CAPACITY_DEF   = 4096;
	localparam int unsigned PROMPT_MAX_DEF = 65535;

	localparam logic [63:0] SEED  = 64'hCBF29CE484222325;
	localparam logic [63:0] MIX_A = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_B = 64'h94D049BB133111EB;
	localparam logic [63:0] GOLD  = 64'h9E3779B97F4A7C15;

	typedef enum logic [2:0] {
		MODE_APPEND     = 3'd0,
		MODE_TRUNC_TO   = 3'd1,
		MODE_TRUNC_LAST = 3'd2,
		MODE_CLEAR      = 3'd3,
		MODE_FP         = 3'd4,
		MODE_PTOKEN     = 3'd5,
		MODE_PEND       = 3'd6,
		MODE_NONE       = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DEC_EXTEND  = 2'd0,
		DEC_RESTORE = 2'd1,
		DEC_RESET   = 2'd2
	} decision_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MIX1,
		S_MIX2,
		S_MIX3,
		S_MIX4,
		S_WRITE,
		S_DONE
	} state_t;

	function automatic logic [63:0] shxor(input logic [63:0] z, input int unsigned s);
		shxor = z ^ (z >> s);
	endfunction

endpackage

// ----- hdl/tlpr_mixer.sv -----
// Multi-cycle splitmix64 finalizer: each 64-bit product built from 32x32 partial products.
module tlpr_mixer import tlpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] din,
	output logic        done,
	output logic [63:0] dout
);
	logic [2:0]  step_q;
	logic        busy_q;
	logic [63:0] z_q;
	logic [63:0] plo_q;
	logic [31:0] pmid_q;
	logic [63:0] cst;
	logic [63:0] psum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
		end else if (go) begin
			busy_q <= 1'b1;
			step_q <= 3'd0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd4) busy_q <= 1'b0;
		end
	end

	assign cst  = (step_q == 3'd0) ? MIX_A : MIX_B;
	assign psum = plo_q + {pmid_q, 32'd0};

	always_ff @(posedge clk) begin
		if (go) begin
			z_q <= shxor(din, 30);
		end else if (busy_q) begin
			unique case (step_q)
				3'd0, 3'd2: begin
					plo_q  <= z_q[31:0] * cst[31:0];
					pmid_q <= z_q[63:32] * cst[31:0] + z_q[31:0] * cst[63:32];
				end
				3'd1:    z_q <= shxor(psum, 27);
				3'd3:    z_q <= shxor(psum, 31);
				default: z_q <= z_q;
			endcase
		end
	end

	assign done = busy_q && (step_q == 3'd4);
	assign dout = z_q;
endmodule

// ----- hdl/tlpr_store.sv -----
// Ledger store: id, tag and hash memories with registered read.
module tlpr_store import tlpr_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wid,
	input  logic [63:0]   wtag,
	input  logic [63:0]   whash,
	input  logic [AW-1:0] iaddr,
	input  logic [AW-1:0] haddr,
	output logic [31:0]   rid,
	output logic [63:0]   rtag,
	output logic [63:0]   rhash
);
	logic [31:0] ids_mem  [CAPACITY];
	logic [63:0] tags_mem [CAPACITY];
	logic [63:0] hash_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			ids_mem[waddr]  <= wid;
			tags_mem[waddr] <= wtag;
			hash_mem[waddr] <= whash;
		end
		rid   <= ids_mem[iaddr];
		rtag  <= tags_mem[iaddr];
		rhash <= hash_mem[haddr];
	end
endmodule

// ----- hdl/token_ledger_prefix_reuse_unit.sv -----
// Top level: token ledger with chained fingerprints and prompt-prefix reuse planning.
// Each transaction takes start while busy is low and returns one result with done high
// for a single cycle; the receiver cannot stall it. An append with room in the ledger runs
// read of the previous hash, mix launch, one pass of the mix unit, write, read-back of the
// new hash and result, with a second mix pass when its content tag is nonzero; every other
// mode, and an append to a full ledger, runs memory read plus result. busy is high from
// the accepting edge until done.
module token_ledger_prefix_reuse_unit import tlpr_pkg::*; #(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned PROMPT_MAX = PROMPT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [31:0] token_id,
	input  logic [63:0] content_tag,
	input  logic [15:0] amount,
	input  logic [15:0] checkpoint_length,
	input  logic        checkpoint_ok,
	output logic        done,
	output logic [1:0]  status,
	output logic [12:0] ledger_length,
	output logic [63:0] fingerprint,
	output logic [12:0] reusable_length,
	output logic        divergent,
	output logic [1:0]  reuse_decision,
	output logic [12:0] reuse_start,
	output logic [15:0] prompt_length
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = $clog2(64'(PROMPT_MAX) + 1);

	state_t state_q, state_d;

	logic [2:0]  mode_q;
	logic [31:0] id_q;
	logic [63:0] tag_q;
	logic [15:0] amt_q;
	logic [15:0] ck_len_q;
	logic        ck_ok_q;

	logic [LW-1:0] used_q;
	logic [PW-1:0] pidx_q;
	logic          match_ok_q;
	logic [LW-1:0] mcount_q;
	logic [63:0]   h_q;
	logic          pass2_q;

	logic          mem_we;
	logic [AW-1:0] iaddr;
	logic [AW-1:0] haddr;
	logic [31:0]   rid;
	logic [63:0]   rtag, rhash;
	logic          mix_go, mix_done;
	logic [63:0]   mix_din, mix_dout;
	logic [63:0]   gold_mul;
	logic [32:0]   id_inc;
	logic [63:0]   gold_lo;
	logic [31:0]   gold_mid;
	logic [63:0]   base_hash;

	logic [LW-1:0] used_new;
	logic [LW-1:0] fp_pos;
	logic [LW-1:0] r_len;

	tlpr_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
		.clk(clk), .we(mem_we), .waddr(used_q[AW-1:0]), .wid(id_q), .wtag(tag_q),
		.whash(mix_dout), .iaddr(iaddr), .haddr(haddr), .rid(rid), .rtag(rtag),
		.rhash(rhash)
	);

	tlpr_mixer u_mix (
		.clk(clk), .arst_n(arst_n), .go(mix_go), .din(mix_din),
		.done(mix_done), .dout(mix_dout)
	);

	// new length per mode, applied in S_READ (append applies at write)
	always_comb begin
		used_new = used_q;
		unique case (mode_t'(mode_q))
			MODE_TRUNC_TO:   if (32'(amt_q) < 32'(used_q))
						used_new = LW'(amt_q);
			MODE_TRUNC_LAST: used_new = (32'(amt_q) >= 32'(used_q)) ? '0
						: LW'(32'(used_q) - 32'(amt_q));
			MODE_CLEAR:      used_new = '0;
			default:         used_new = used_q;
		endcase
	end

	assign fp_pos = (mode_t'(mode_q) == MODE_FP && 32'(amt_q) < 32'(used_q))
			? LW'(amt_q) : used_new;
	assign r_len = (mcount_q < used_q) ? mcount_q : used_q;

	assign iaddr = AW'(pidx_q);

	always_comb begin
		haddr = '0;
		unique case (state_q)
			S_IDLE:  haddr = '0;
			S_READ:  haddr = AW'(fp_pos - LW'(1));
			default: haddr = AW'(used_q - LW'(1));
		endcase
	end

	assign id_inc   = {1'b0, id_q} + 33'd1;
	assign gold_lo  = id_inc[31:0] * GOLD[31:0];
	assign gold_mid = id_inc[31:0] * GOLD[63:32] + (id_inc[32] ? GOLD[31:0] : 32'd0);
	assign gold_mul = gold_lo + {gold_mid, 32'd0};

	assign base_hash = (used_q == '0) ? SEED : rhash;
	assign mix_din   = (state_q == S_MIX2) ? (mix_dout ^ tag_q) : (base_hash ^ h_q);

	assign mem_we = (state_q == S_WRITE);

	always_comb begin
		state_d = state_q;
		mix_go  = 1'b0;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_READ;
			S_READ:  state_d = (mode_t'(mode_q) == MODE_APPEND && 32'(used_q) < CAPACITY)
					? S_MIX1 : S_DONE;
			S_MIX1:  begin
				mix_go  = 1'b1;
				state_d = S_MIX2;
			end
			S_MIX2:  if (mix_done) begin
				if (!pass2_q && tag_q != '0) begin
					mix_go  = 1'b1;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: state_d = S_READ;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q   <= mode;
			id_q     <= token_id;
			tag_q    <= content_tag;
			amt_q    <= amount;
			ck_len_q <= checkpoint_length;
			ck_ok_q  <= checkpoint_ok;
		end else if (state_q == S_WRITE) begin
			mode_q   <= MODE_NONE;
		end
		if (state_q == S_READ) h_q <= gold_mul;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			pidx_q     <= '0;
			match_ok_q <= 1'b1;
			mcount_q   <= '0;
			pass2_q    <= 1'b0;
			done            <= 1'b0;
			status          <= ST_OK;
			ledger_length   <= '0;
			fingerprint     <= '0;
			reusable_length <= '0;
			divergent       <= 1'b0;
			reuse_decision  <= DEC_EXTEND;
			reuse_start     <= '0;
			prompt_length   <= '0;
		end else begin
			done <= 1'b0;
			if (state_q == S_MIX1) pass2_q <= 1'b0;
			if (state_q == S_MIX2 && mix_done && !pass2_q && tag_q != '0) pass2_q <= 1'b1;
			if (state_q == S_WRITE) begin
				used_q  <= used_q + LW'(1);
			end
			if (state_q == S_READ) begin
				if (!(mode_t'(mode_q) == MODE_APPEND && 32'(used_q) < CAPACITY)) begin
					used_q <= used_new;
				end
				status          <= ST_OK;
				reusable_length <= '0;
				divergent       <= 1'b0;
				reuse_decision  <= DEC_EXTEND;
				reuse_start     <= '0;
				prompt_length   <= '0;
				if (mode_t'(mode_q) == MODE_APPEND) status <= ST_FULL;
				if (mode_t'(mode_q) == MODE_PTOKEN && 64'(pidx_q) >= 64'(PROMPT_MAX))
					status <= ST_SAT;
				if (mode_t'(mode_q) == MODE_PEND) begin
					reusable_length <= 13'(r_len);
					prompt_length   <= 16'(pidx_q);
					if (r_len >= used_q) begin
						reuse_decision <= DEC_EXTEND;
						reuse_start    <= 13'(r_len);
					end else begin
						divergent <= 1'b1;
						if (!ck_ok_q || ck_len_q == '0 || 64'(ck_len_q) > 64'(pidx_q) ||
						    32'(ck_len_q) > 32'(r_len)) begin
							reuse_decision <= DEC_RESET;
							reuse_start    <= '0;
						end else begin
							reuse_decision <= DEC_RESTORE;
							reuse_start    <= 13'(ck_len_q);
						end
					end
					pidx_q     <= '0;
					match_ok_q <= 1'b1;
					mcount_q   <= '0;
				end
			end
			if (state_q == S_DONE) begin
				if (mode_t'(mode_q) == MODE_PTOKEN && 64'(pidx_q) < 64'(PROMPT_MAX)) begin
					if (match_ok_q) begin
						if (32'(pidx_q) < 32'(used_q) && rid == id_q && rtag == tag_q)
							mcount_q <= LW'(pidx_q + PW'(1));
						else
							match_ok_q <= 1'b0;
					end
					pidx_q <= pidx_q + PW'(1);
				end
				done          <= 1'b1;
				ledger_length <= 13'(used_q);
				fingerprint   <= (used_q == '0 || (mode_t'(mode_q) == MODE_FP &&
						32'(amt_q) == 32'd0)) ? SEED : rhash;
			end
		end
	end

`ifndef SYNTHESIS
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= CAPACITY) else $error("ledger length over capacity");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_write_grow: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> used_q == $past(used_q) + LW'(1)) else $error("append length");
	a_pidx_cap: assert property (@(posedge clk) disable iff (!arst_n)
		64'(pidx_q) <= 64'(PROMPT_MAX)) else $error("prompt index over max");
`endif
endmodule

// ----- bench/tb_top.sv -----
// Testbench: drives ledger and prompt transactions and checks results against a predictor.
module tb_top;
	import tlpr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP = 4096;
	localparam int unsigned PMAX = 65535;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [31:0] token_id;
	logic [63:0] content_tag;
	logic [15:0] amount;
	logic [15:0] checkpoint_length;
	logic        checkpoint_ok;
	logic        done;
	logic [1:0]  status;
	logic [12:0] ledger_length;
	logic [63:0] fingerprint;
	logic [12:0] reusable_length;
	logic        divergent;
	logic [1:0]  reuse_decision;
	logic [12:0] reuse_start;
	logic [15:0] prompt_length;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] ledger_length;
		logic [63:0] fingerprint;
		logic [12:0] reusable_length;
		logic        divergent;
		logic [1:0]  reuse_decision;
		logic [12:0] reuse_start;
		logic [15:0] prompt_length;
	} ledger_result_t;

	token_ledger_prefix_reuse_unit dut (.*);

	logic [31:0] led_ids [CAP];
	logic [63:0] led_tags [CAP];
	logic [63:0] led_fps [CAP];
	int unsigned led_len;
	int unsigned prm_idx;
	bit          prm_matching;
	int unsigned prm_matched;

	ledger_result_t pending_results [$];
	int unsigned    mismatches;
	bit             failed;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic logic [63:0] splitmix(input logic [63:0] z);
		z = z ^ (z >> 30);
		z = z * 64'hBF58476D1CE4E5B9;
		z = z ^ (z >> 27);
		z = z * 64'h94D049BB133111EB;
		return z ^ (z >> 31);
	endfunction

	function automatic logic [63:0] fp_at(input int unsigned pos);
		if (pos == 0)
			return 64'hCBF29CE484222325;
		return led_fps[pos - 1];
	endfunction

	function automatic ledger_result_t predict_ledger(input mode_t m, input logic [31:0] id,
			input logic [63:0] tag, input logic [15:0] amt, input logic [15:0] ck_len,
			input logic ck_ok);
		ledger_result_t r;
		logic [63:0] h;
		int unsigned reuse;
		int unsigned pos;
		r = '0;
		case (m)
			MODE_APPEND: begin
				if (led_len >= CAP) begin
					r.status = ST_FULL;
				end else begin
					h = splitmix(fp_at(led_len) ^ (64'h9E3779B97F4A7C15 * ({32'd0, id} + 64'd1)));
					if (tag != 0)
						h = splitmix(h ^ tag);
					led_ids[led_len] = id;
					led_tags[led_len] = tag;
					led_fps[led_len] = h;
					led_len++;
				end
			end
			MODE_TRUNC_TO: begin
				if (amt < led_len)
					led_len = 32'(amt);
			end
			MODE_TRUNC_LAST: led_len = (amt >= led_len) ? 0 : led_len - amt;
			MODE_CLEAR: led_len = 0;
			MODE_PTOKEN: begin
				if (prm_idx >= PMAX) begin
					r.status = ST_SAT;
				end else begin
					if (prm_matching) begin
						if (prm_idx < led_len && led_ids[prm_idx] == id && led_tags[prm_idx] == tag)
							prm_matched = prm_idx + 1;
						else
							prm_matching = 1'b0;
					end
					prm_idx++;
				end
			end
			MODE_PEND: begin
				reuse = (prm_matched < led_len) ? prm_matched : led_len;
				r.reusable_length = 13'(reuse);
				r.prompt_length = 16'(prm_idx);
				if (reuse >= led_len) begin
					r.reuse_decision = DEC_EXTEND;
					r.reuse_start = 13'(reuse);
				end else begin
					r.divergent = 1'b1;
					if (!ck_ok || ck_len == 0 || ck_len > prm_idx || ck_len > led_len
							|| ck_len > reuse) begin
						r.reuse_decision = DEC_RESET;
					end else begin
						r.reuse_decision = DEC_RESTORE;
						r.reuse_start = 13'(ck_len);
					end
				end
				prm_idx = 0;
				prm_matching = 1'b1;
				prm_matched = 0;
			end
			default: ;
		endcase
		pos = led_len;
		if (m == MODE_FP && amt < led_len)
			pos = 32'(amt);
		r.ledger_length = 13'(led_len);
		r.fingerprint = fp_at(pos);
		return r;
	endfunction

	task automatic idle_gap();
		int unsigned n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		repeat (n) @(negedge clk);
	endtask

	task automatic send_item(input mode_t m, input logic [31:0] id, input logic [63:0] tag,
			input logic [15:0] amt, input logic [15:0] ck_len = 0, input logic ck_ok = 0,
			input bit gaps = 1'b1);
		if (gaps)
			idle_gap();
		while (busy)
			@(negedge clk);
		mode <= m;
		token_id <= id;
		content_tag <= tag;
		amount <= amt;
		checkpoint_length <= ck_len;
		checkpoint_ok <= ck_ok;
		start <= 1'b1;
		pending_results.insert(pending_results.size(),
			predict_ledger(m, id, tag, amt, ck_len, ck_ok));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		ledger_result_t got;
		ledger_result_t want;
		if (arst_n && done) begin
			got = '{status, ledger_length, fingerprint, reusable_length, divergent,
				reuse_decision, reuse_start, prompt_length};
			if (pending_results.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	function automatic logic [63:0] rand_tag();
		case ($urandom_range(0, 3))
			0: return 64'd0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_directed();
		send_item(MODE_FP, 0, 0, 16'hFFFF);
		send_item(MODE_PEND, 0, 0, 0, 16'hFFFF, 1);
		send_item(MODE_APPEND, 32'd0, 64'd0, 0);
		send_item(MODE_APPEND, 32'hFFFFFFFF, '1, 0);
		send_item(MODE_APPEND, 32'h12345678, 64'h0123456789ABCDEF, 0);
		send_item(MODE_APPEND, 32'h5, 64'd0, 0);
		send_item(MODE_FP, 0, 0, 0);
		send_item(MODE_FP, 0, 0, 2);
		send_item(MODE_FP, 0, 0, 16'hFFFF);
		send_item(MODE_NONE, '1, '1, '1, '1, 1);
		send_item(MODE_PTOKEN, 32'd0, 64'd0, 0);
		send_item(MODE_PTOKEN, 32'hFFFFFFFF, '1, 0);
		send_item(MODE_PTOKEN, 32'd9, 64'd0, 0);
		send_item(MODE_PTOKEN, 32'd9, 64'd0, 0);
		send_item(MODE_TRUNC_TO, 0, 0, 3);
		send_item(MODE_PEND, 0, 0, 0, 16'd1, 1);
		send_item(MODE_PTOKEN, 32'd0, 64'd0, 0);
		send_item(MODE_PEND, 0, 0, 0, 16'd1, 1);
		send_item(MODE_TRUNC_TO, 0, 0, 16'hFFFF);
		send_item(MODE_TRUNC_LAST, 0, 0, 1);
		send_item(MODE_TRUNC_LAST, 0, 0, 16'hFFFF);
		send_item(MODE_APPEND, 32'd1, 64'd0, 0);
		send_item(MODE_CLEAR, '1, '1, '1, '1, 1);
		drain_results();
	endtask

	task automatic test_random_sessions(input int unsigned sessions);
		int unsigned plen;
		int unsigned k;
		logic [31:0] id;
		logic [63:0] tag;
		for (int s = 0; s < sessions; s++) begin
			repeat ($urandom_range(0, 8))
				send_item(MODE_APPEND, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7),
					rand_tag(), 0);
			if ($urandom_range(0, 3) == 0)
				send_item(mode_t'($urandom_range(1, 4)), $urandom, rand_tag(),
					16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20)));
			plen = $urandom_range(0, ((led_len < 12) ? led_len : 12) + 3);
			for (int i = 0; i < plen; i++) begin
				if (i < led_len && $urandom_range(0, 7) != 0) begin
					id = led_ids[i];
					tag = led_tags[i];
				end else begin
					id = $urandom;
					tag = rand_tag();
				end
				send_item(MODE_PTOKEN, id, tag, 16'($urandom));
				if ($urandom_range(0, 15) == 0)
					send_item(mode_t'($urandom_range(0, 7)), $urandom, rand_tag(),
						16'($urandom_range(0, 30)));
			end
			k = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, led_len + 1);
			send_item(MODE_PEND, $urandom, rand_tag(), 16'($urandom), 16'(k),
				$urandom_range(0, 3) != 0);
			if (s == sessions / 2)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		failed = 1'b0;
		mismatches = 0;
		led_len = 0;
		prm_idx = 0;
		prm_matching = 1'b1;
		prm_matched = 0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_NONE;
		token_id = '0;
		content_tag = '0;
		amount = '0;
		checkpoint_length = '0;
		checkpoint_ok = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_sessions(73);
		test_random_sessions(73);
		repeat (20) @(negedge clk);
		if (!failed && pending_results.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
